// ===== rtl/lmc_pkg.sv =====
// ============================================================================
// lmc_pkg: shared types and constants for the LMC instruction step unit
// Word layouts for both channels, the internal command format, status and
// opcode codes, and the back-end state encoding.
// ============================================================================
package lmc_pkg;

    localparam int MAILBOX_COUNT   = 100;
    localparam int ADDR_W          = 7;
    localparam int DATA_W          = 32;
    localparam int OPC_W           = 4;
    localparam int CMD_QUEUE_DEPTH = 2;

    // Opcodes (hundreds digit of an instruction word)
    localparam logic [OPC_W-1:0] OPC_ADD = 4'd1;
    localparam logic [OPC_W-1:0] OPC_SUB = 4'd2;
    localparam logic [OPC_W-1:0] OPC_STA = 4'd3;
    localparam logic [OPC_W-1:0] OPC_LDA = 4'd5;
    localparam logic [OPC_W-1:0] OPC_BRA = 4'd6;
    localparam logic [OPC_W-1:0] OPC_BRZ = 4'd7;
    localparam logic [OPC_W-1:0] OPC_BRP = 4'd8;
    localparam logic [OPC_W-1:0] OPC_IO  = 4'd9;

    // Operand codes of the I/O group
    localparam logic [ADDR_W-1:0] IO_INP = 7'd1;
    localparam logic [ADDR_W-1:0] IO_OUT = 7'd2;
    localparam logic [ADDR_W-1:0] IO_OTC = 7'd22;

    // Largest instruction word plus one
    localparam logic [DATA_W-1:0] INSTR_LIMIT = 32'd1000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HALT      = 3'd1,
        ST_BAD_PC    = 3'd2,
        ST_BAD_INSTR = 3'd3,
        ST_BAD_INPUT = 3'd4
    } lmc_status_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SKIP,
        CMD_STEP
    } lmc_cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_OPER
    } lmc_state_t;

    typedef struct packed {
        logic                     func;
        logic [ADDR_W-1:0]        load_address;
        logic signed [DATA_W-1:0] load_word;
        logic signed [DATA_W-1:0] input_value;
        logic                     input_ok;
    } lmc_in_t;

    typedef struct packed {
        lmc_status_t              status;
        logic                     out_valid;
        logic                     out_is_char;
        logic signed [DATA_W-1:0] out_value;
        logic [ADDR_W-1:0]        pc_now;
        logic signed [DATA_W-1:0] acc_now;
    } lmc_out_t;

    // Classified command passed from front end to back end
    typedef struct packed {
        lmc_cmd_kind_t     kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              input_ok;
    } lmc_cmd_t;

endpackage

// ===== rtl/lmc_instruction_step_unit.sv =====
// ============================================================================
// lmc_instruction_step_unit: Little Man Computer core, one word per step
// Top level: classifier, command queue and execution back end.
// ============================================================================
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_word): each word is a mailbox
//   load (func = 0) or one instruction step (func = 1). res channel
//   (res_valid / res_stall / res_word): exactly one result word per cmd word,
//   in order, carrying status, optional OUT/OTC value, PC and accumulator.
//
// Path from cmd accept to res_valid (receiver not stalling):
//   load, bad PC           queue head straight to the result register
//   HLT, STA, branch, I/O  dispatch, fetch
//   ADD, SUB, LDA          dispatch, fetch, operand read
// A load every cycle unless res_stall holds; steps do not overlap. The mailbox
// read is registered and the operand address comes out of the fetched word.
//
// A 2-word command queue decouples intake from execution, so cmd words are
// taken while the back end works or while a result waits in the output
// register. When res_stall holds, the result word stays put, the back end
// waits, and cmd_stall rises once the queue is full.
//
// Reset clears PC, accumulator, queue occupancy and res_valid. Mailboxes read as
// zero until written (per-entry fill flags); there is no clearing pass.
// ============================================================================
module lmc_instruction_step_unit #(
    parameter int MAILBOX_COUNT = lmc_pkg::MAILBOX_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  lmc_pkg::lmc_in_t  cmd_word,
    output logic              res_valid,
    input  logic              res_stall,
    output lmc_pkg::lmc_out_t res_word
);

    lmc_pkg::lmc_cmd_t front_cmd;
    lmc_pkg::lmc_cmd_t q_head_cmd;
    logic              q_full;
    logic              q_head_valid;
    logic              q_push;
    logic              q_pop;

    lmc_front #(
        .MAILBOX_COUNT (MAILBOX_COUNT)
    ) u_front (
        .item (cmd_word),
        .cmd  (front_cmd)
    );

    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;

    lmc_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    lmc_back #(
        .MAILBOX_COUNT (MAILBOX_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word)
    );

    // ---- assertions ----

    // back end never retires a command the queue does not hold
    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("command retired from empty queue");

    // PC only leaves the mailbox range by running off the end
    a_bad_pc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.status == lmc_pkg::ST_BAD_PC)
        |-> (32'(res_word.pc_now) == MAILBOX_COUNT))
        else $error("bad PC status with PC not at end of memory");

    // output data only comes from a successful step
    a_out_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_valid |-> (res_word.status == lmc_pkg::ST_OK))
        else $error("output flagged on failed step");

    // character output is a single byte
    a_char_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.out_is_char
        |-> res_word.out_valid && (res_word.out_value[31:8] == '0))
        else $error("character output malformed");

endmodule

// ===== rtl/lmc_front.sv =====
// ============================================================================
// lmc_front: input word classifier
// Sorts each incoming word into a mailbox load, a dropped load (address out
// of range) or an instruction step, and packs the one data word it needs.
// ============================================================================
module lmc_front #(
    parameter int MAILBOX_COUNT = lmc_pkg::MAILBOX_COUNT
) (
    input  lmc_pkg::lmc_in_t  item,
    output lmc_pkg::lmc_cmd_t cmd
);

    always_comb
    begin
        cmd.addr     = item.load_address;
        cmd.input_ok = item.input_ok;
        if (item.func)
        begin
            cmd.kind = lmc_pkg::CMD_STEP;
            cmd.data = item.input_value;
        end
        else if (32'(item.load_address) < MAILBOX_COUNT)
        begin
            cmd.kind = lmc_pkg::CMD_LOAD;
            cmd.data = item.load_word;
        end
        else
        begin
            cmd.kind = lmc_pkg::CMD_SKIP;
            cmd.data = item.load_word;
        end
    end

endmodule

// ===== rtl/lmc_cmd_queue.sv =====
// ============================================================================
// lmc_cmd_queue: command queue between front and back end
// Small FIFO of classified commands; full stalls the input channel.
// ============================================================================
module lmc_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lmc_pkg::lmc_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output lmc_pkg::lmc_cmd_t head_cmd
);

    localparam int DEPTH = lmc_pkg::CMD_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lmc_pkg::lmc_cmd_t slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/lmc_back.sv =====
// ============================================================================
// lmc_back: execution back end
// Sequencer over the mailbox memory: fetch, decode, optional operand read,
// then write back PC/accumulator and register the result word.
// ============================================================================
module lmc_back #(
    parameter int MAILBOX_COUNT = lmc_pkg::MAILBOX_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  lmc_pkg::lmc_cmd_t head_cmd,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output lmc_pkg::lmc_out_t res_word
);

    localparam int AW     = $clog2(MAILBOX_COUNT);
    localparam int ADDR_W = lmc_pkg::ADDR_W;
    localparam int DATA_W = lmc_pkg::DATA_W;
    localparam int OPC_W  = lmc_pkg::OPC_W;

    lmc_pkg::lmc_state_t state_reg, state_next;

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [OPC_W-1:0]  op_reg, op_next;

    logic              res_valid_reg, res_valid_next;
    lmc_pkg::lmc_out_t res_word_reg, res_word_next;

    // mailbox memory; filled flags make never-written entries read as zero
    logic [DATA_W-1:0]        mbox_mem_reg [MAILBOX_COUNT];
    logic [MAILBOX_COUNT-1:0] filled_reg;
    logic [DATA_W-1:0]        mbox_q_reg;
    logic                     filled_q_reg;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic              out_free, done;
    logic              step_go, need_oper;
    logic [DATA_W-1:0] rd_word;
    logic              dec_ok;
    logic [OPC_W-1:0]  dec_opc;
    logic [9:0]        dec_base, dec_rem;
    logic [ADDR_W-1:0] dec_operand;
    logic [AW-1:0]     dec_addr;
    logic [ADDR_W-1:0] pc_inc;

    lmc_pkg::lmc_status_t status_c;
    logic                 ov_c, oc_c;
    logic [DATA_W-1:0]    oval_c;

    assign out_free = !res_valid_reg || !res_stall;
    assign pc_inc   = pc_reg + ADDR_W'(1);

    // ---- decode of the fetched word ----
    always_comb
    begin
        rd_word  = filled_q_reg ? mbox_q_reg : '0;
        dec_ok   = (rd_word < lmc_pkg::INSTR_LIMIT);
        dec_opc  = '0;
        dec_base = '0;
        for (int i = 1; i <= 9; i++)
        begin
            if (rd_word[9:0] >= 10'(i * 100))
            begin
                dec_opc  = OPC_W'(i);
                dec_base = 10'(i * 100);
            end
        end
        dec_rem     = rd_word[9:0] - dec_base;
        dec_operand = dec_rem[ADDR_W-1:0];
        dec_addr    = (32'(dec_operand) >= MAILBOX_COUNT) ? '0 : dec_operand[AW-1:0];
        need_oper   = dec_ok && (dec_opc inside {lmc_pkg::OPC_ADD, lmc_pkg::OPC_SUB,
                                                 lmc_pkg::OPC_LDA});
        step_go     = head_valid && (head_cmd.kind == lmc_pkg::CMD_STEP)
                      && (32'(pc_reg) < MAILBOX_COUNT);
    end

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmc_pkg::BK_IDLE:
            begin
                if (step_go)
                begin
                    state_next = lmc_pkg::BK_FETCH;
                end
            end
            lmc_pkg::BK_FETCH:
            begin
                if (need_oper)
                begin
                    state_next = lmc_pkg::BK_OPER;
                end
                else if (out_free)
                begin
                    state_next = lmc_pkg::BK_IDLE;
                end
            end
            lmc_pkg::BK_OPER:
            begin
                if (out_free)
                begin
                    state_next = lmc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lmc_pkg::BK_IDLE;
            end
        endcase
    end

    // ---- datapath and memory control ----
    always_comb
    begin
        done     = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = acc_reg;
        pc_next  = pc_reg;
        acc_next = acc_reg;
        op_next  = op_reg;
        status_c = lmc_pkg::ST_OK;
        ov_c     = 1'b0;
        oc_c     = 1'b0;
        oval_c   = '0;

        unique case (state_reg)
            lmc_pkg::BK_IDLE:
            begin
                if (step_go)
                begin
                    rd_en   = 1'b1;
                    rd_addr = pc_reg[AW-1:0];
                end
                else if (head_valid && out_free)
                begin
                    done = 1'b1;
                    unique case (head_cmd.kind)
                        lmc_pkg::CMD_LOAD:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = head_cmd.addr[AW-1:0];
                            wr_data = head_cmd.data;
                        end
                        lmc_pkg::CMD_STEP:
                        begin
                            // step with PC past the last mailbox
                            status_c = lmc_pkg::ST_BAD_PC;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            lmc_pkg::BK_FETCH:
            begin
                if (need_oper)
                begin
                    rd_en   = 1'b1;
                    rd_addr = dec_addr;
                    op_next = dec_opc;
                end
                else if (out_free)
                begin
                    done = 1'b1;
                    if (rd_word == '0)
                    begin
                        status_c = lmc_pkg::ST_HALT;
                    end
                    else if (!dec_ok)
                    begin
                        status_c = lmc_pkg::ST_BAD_INSTR;
                    end
                    else
                    begin
                        unique case (dec_opc)
                            lmc_pkg::OPC_STA:
                            begin
                                wr_en   = 1'b1;
                                wr_addr = dec_addr;
                                pc_next = pc_inc;
                            end
                            lmc_pkg::OPC_BRA:
                            begin
                                pc_next = ADDR_W'(dec_addr);
                            end
                            lmc_pkg::OPC_BRZ:
                            begin
                                pc_next = (acc_reg == '0) ? ADDR_W'(dec_addr) : pc_inc;
                            end
                            lmc_pkg::OPC_BRP:
                            begin
                                pc_next = acc_reg[DATA_W-1] ? pc_inc : ADDR_W'(dec_addr);
                            end
                            lmc_pkg::OPC_IO:
                            begin
                                if (dec_operand == lmc_pkg::IO_INP)
                                begin
                                    if (head_cmd.input_ok)
                                    begin
                                        acc_next = head_cmd.data;
                                        pc_next  = pc_inc;
                                    end
                                    else
                                    begin
                                        status_c = lmc_pkg::ST_BAD_INPUT;
                                    end
                                end
                                else if (dec_operand == lmc_pkg::IO_OUT)
                                begin
                                    ov_c    = 1'b1;
                                    oval_c  = acc_reg;
                                    pc_next = pc_inc;
                                end
                                else if (dec_operand == lmc_pkg::IO_OTC)
                                begin
                                    ov_c    = 1'b1;
                                    oc_c    = 1'b1;
                                    oval_c  = {{(DATA_W - 8){1'b0}}, acc_reg[7:0]};
                                    pc_next = pc_inc;
                                end
                                else
                                begin
                                    status_c = lmc_pkg::ST_BAD_INSTR;
                                end
                            end
                            default:
                            begin
                                status_c = lmc_pkg::ST_BAD_INSTR;
                            end
                        endcase
                    end
                end
            end

            lmc_pkg::BK_OPER:
            begin
                if (out_free)
                begin
                    done    = 1'b1;
                    pc_next = pc_inc;
                    case (op_reg)
                        lmc_pkg::OPC_ADD: acc_next = acc_reg + rd_word;
                        lmc_pkg::OPC_SUB: acc_next = acc_reg - rd_word;
                        default:          acc_next = rd_word;
                    endcase
                end
            end

            default:
            begin
            end
        endcase

        pop            = done;
        res_valid_next = done || (res_valid_reg && res_stall);
        res_word_next  = res_word_reg;
        if (done)
        begin
            res_word_next.status      = status_c;
            res_word_next.out_valid   = ov_c;
            res_word_next.out_is_char = oc_c;
            res_word_next.out_value   = oval_c;
            res_word_next.pc_now      = pc_next;
            res_word_next.acc_now     = acc_next;
        end
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmc_pkg::BK_IDLE;
            pc_reg        <= '0;
            acc_reg       <= '0;
            op_reg        <= '0;
            res_valid_reg <= 1'b0;
            filled_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            op_reg        <= op_next;
            res_valid_reg <= res_valid_next;
            if (wr_en)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

    // ---- mailbox memory: one write, one registered read per cycle ----
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mbox_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mbox_q_reg <= mbox_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_q_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            filled_q_reg <= filled_reg[rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for lmc_instruction_step_unit
// Drives mailbox loads and instruction steps through the cmd channel and
// checks every res word against a cycle-free model of the LMC core. A short
// directed table covers reset, range limits and error codes; a long random
// phase then runs small random programs with random gaps and back-pressure.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int RAND_ITEMS = 800;
    localparam int DATA_W     = lmc_pkg::DATA_W;
    localparam int ADDR_W     = lmc_pkg::ADDR_W;

    typedef struct packed {
        lmc_pkg::lmc_in_t  word;
        logic              fixed;   // 1: res is typed in, 0: use the model
        lmc_pkg::lmc_out_t res;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    lmc_pkg::lmc_in_t  cmd_word;
    logic              res_valid;
    logic              res_stall;
    lmc_pkg::lmc_out_t res_word;

    // Model state
    logic [DATA_W-1:0] mem_img [lmc_pkg::MAILBOX_COUNT];
    logic [ADDR_W-1:0] pc_img;
    logic [DATA_W-1:0] acc_img;

    lmc_pkg::lmc_out_t pending_q [$];
    dir_row_t          dir_tab [$];
    int                fail_count = 0;

    // Back-pressure shaping
    int cycle_cnt  = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    lmc_instruction_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always #1 clk = ~clk;

    // Executes one word against the model state and returns its result.
    function automatic lmc_pkg::lmc_out_t lmc_execute(lmc_pkg::lmc_in_t w);
        lmc_pkg::lmc_out_t r;
        logic [DATA_W-1:0] instr;
        int                sw;
        int                opc;
        int                opd;
        int                ea;
        logic [ADDR_W-1:0] npc;
        r = '0;
        r.status = lmc_pkg::ST_OK;
        if (!w.func)
        begin
            if (w.load_address < lmc_pkg::MAILBOX_COUNT)
                mem_img[w.load_address] = w.load_word;
        end
        else if (pc_img >= lmc_pkg::MAILBOX_COUNT)
        begin
            r.status = lmc_pkg::ST_BAD_PC;
        end
        else
        begin
            instr = mem_img[pc_img];
            sw    = instr;
            opc   = sw / 100;     // truncates toward zero
            opd   = sw % 100;
            ea    = (opd >= 0) ? opd : 0;
            npc   = pc_img + 7'd1;
            if (instr == '0)
                r.status = lmc_pkg::ST_HALT;
            else if (opc == int'(lmc_pkg::OPC_ADD))
                acc_img = acc_img + mem_img[ea];
            else if (opc == int'(lmc_pkg::OPC_SUB))
                acc_img = acc_img - mem_img[ea];
            else if (opc == int'(lmc_pkg::OPC_STA))
                mem_img[ea] = acc_img;
            else if (opc == int'(lmc_pkg::OPC_LDA))
                acc_img = mem_img[ea];
            else if (opc == int'(lmc_pkg::OPC_BRA))
                npc = ADDR_W'(ea);
            else if (opc == int'(lmc_pkg::OPC_BRZ))
            begin
                if (acc_img == '0)
                    npc = ADDR_W'(ea);
            end
            else if (opc == int'(lmc_pkg::OPC_BRP))
            begin
                if (!acc_img[DATA_W-1])
                    npc = ADDR_W'(ea);
            end
            else if (opc == int'(lmc_pkg::OPC_IO) && opd == int'(lmc_pkg::IO_INP))
            begin
                if (w.input_ok)
                    acc_img = w.input_value;
                else
                    r.status = lmc_pkg::ST_BAD_INPUT;
            end
            else if (opc == int'(lmc_pkg::OPC_IO) && opd == int'(lmc_pkg::IO_OUT))
            begin
                r.out_valid = 1'b1;
                r.out_value = acc_img;
            end
            else if (opc == int'(lmc_pkg::OPC_IO) && opd == int'(lmc_pkg::IO_OTC))
            begin
                r.out_valid   = 1'b1;
                r.out_is_char = 1'b1;
                r.out_value   = {24'd0, acc_img[7:0]};
            end
            else
                r.status = lmc_pkg::ST_BAD_INSTR;
            if (r.status == lmc_pkg::ST_OK)
                pc_img = npc;
        end
        r.pc_now  = pc_img;
        r.acc_now = acc_img;
        return r;
    endfunction

    function automatic lmc_pkg::lmc_in_t ld_word(logic [ADDR_W-1:0] a,
                                                 logic [DATA_W-1:0] d);
        lmc_pkg::lmc_in_t w;
        w = '0;
        w.load_address = a;
        w.load_word    = d;
        return w;
    endfunction

    function automatic lmc_pkg::lmc_in_t step_word(logic [DATA_W-1:0] v, logic ok);
        lmc_pkg::lmc_in_t w;
        w = '0;
        w.func        = 1'b1;
        w.input_value = v;
        w.input_ok    = ok;
        return w;
    endfunction

    function automatic lmc_pkg::lmc_out_t fix_res(lmc_pkg::lmc_status_t st,
                                                  logic [ADDR_W-1:0] pc,
                                                  logic [DATA_W-1:0] acc);
        lmc_pkg::lmc_out_t r;
        r = '0;
        r.status  = st;
        r.pc_now  = pc;
        r.acc_now = acc;
        return r;
    endfunction

    task automatic add_row(lmc_pkg::lmc_in_t w, logic f, lmc_pkg::lmc_out_t r);
        dir_tab.push_back('{w, f, r});
    endtask

    // Random mailbox content: mostly legal instructions, some data and junk.
    function automatic logic [DATA_W-1:0] gen_instr();
        int k;
        int d;
        k = $urandom_range(0, 99);
        d = $urandom_range(0, 99);
        if (k < 70)
        begin
            case ($urandom_range(0, 9))
                0: return 32'(int'(lmc_pkg::OPC_ADD) * 100 + d);
                1: return 32'(int'(lmc_pkg::OPC_SUB) * 100 + d);
                2: return 32'(int'(lmc_pkg::OPC_STA) * 100 + d);
                3: return 32'(int'(lmc_pkg::OPC_LDA) * 100 + d);
                4: return 32'(int'(lmc_pkg::OPC_BRA) * 100 + d);
                5: return 32'(int'(lmc_pkg::OPC_BRZ) * 100 + d);
                6: return 32'(int'(lmc_pkg::OPC_BRP) * 100 + d);
                7: return 32'(int'(lmc_pkg::OPC_IO) * 100 + int'(lmc_pkg::IO_INP));
                8: return 32'(int'(lmc_pkg::OPC_IO) * 100 + int'(lmc_pkg::IO_OUT));
                default: return 32'(int'(lmc_pkg::OPC_IO) * 100 + int'(lmc_pkg::IO_OTC));
            endcase
        end
        if (k < 74)
            return '0;
        if (k < 80)
            return $urandom;
        if (k < 84)
            return {1'b1, 31'($urandom)};
        if (k < 87)
            return 32'($urandom_range(1, 99));
        if (k < 90)
            return 32'(400 + d);
        if (k < 94)
        begin
            if (d == int'(lmc_pkg::IO_INP) || d == int'(lmc_pkg::IO_OUT)
                || d == int'(lmc_pkg::IO_OTC))
                d = 50;
            return 32'(int'(lmc_pkg::OPC_IO) * 100 + d);
        end
        return $urandom_range(32'h7FFF_FFFF, 1000);
    endfunction

    function automatic int next_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return 0;
        if (k < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one word, waits for acceptance, then records the expected result.
    task automatic issue_word(lmc_pkg::lmc_in_t w, int gap, logic use_fix,
                              lmc_pkg::lmc_out_t fix);
        lmc_pkg::lmc_out_t pred;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        pred = lmc_execute(w);
        pending_q.push_back(use_fix ? fix : pred);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
    endtask

    task automatic check_result(lmc_pkg::lmc_out_t exp, lmc_pkg::lmc_out_t got);
        logic bad;
        bad = 1'b0;
        if (got.status !== exp.status)
        begin
            $error("status expected %0d got %0d", exp.status, got.status);
            bad = 1'b1;
        end
        if (got.out_valid !== exp.out_valid)
        begin
            $error("out_valid expected %0d got %0d", exp.out_valid, got.out_valid);
            bad = 1'b1;
        end
        if (got.out_is_char !== exp.out_is_char)
        begin
            $error("out_is_char expected %0d got %0d", exp.out_is_char, got.out_is_char);
            bad = 1'b1;
        end
        if (got.out_value !== exp.out_value)
        begin
            $error("out_value expected %h got %h", exp.out_value, got.out_value);
            bad = 1'b1;
        end
        if (got.pc_now !== exp.pc_now)
        begin
            $error("pc_now expected %0d got %0d", exp.pc_now, got.pc_now);
            bad = 1'b1;
        end
        if (got.acc_now !== exp.acc_now)
        begin
            $error("acc_now expected %h got %h", exp.acc_now, got.acc_now);
            bad = 1'b1;
        end
        if (bad)
            fail_count++;
    endtask

    // Result monitor and res_stall generator. Values read here are the ones
    // sampled at this edge, since everything in the design updates via NBAs.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("res word with no expectation pending");
                fail_count++;
            end
            else
                check_result(pending_q.pop_front(), res_word);
        end
        cycle_cnt++;
        if (cycle_cnt % 300 == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 40;
                default: stall_pct = 70;
            endcase
        end
        if (!rst_n)
            res_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            res_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end
        else
            res_stall <= 1'b0;
    end

    initial
    begin
        int               i;
        int               pick;
        lmc_pkg::lmc_in_t w;
        pc_img     = '0;
        acc_img    = '0;
        foreach (mem_img[k]) mem_img[k] = '0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_word  <= '0;

        // Directed table. Typed-in results only where they are obvious.
        add_row(step_word(32'h0, 1'b1), 1'b1, fix_res(lmc_pkg::ST_HALT, 7'd0, 32'h0));
        add_row(ld_word(7'd127, 32'h8000_0000), 1'b1,
                fix_res(lmc_pkg::ST_OK, 7'd0, 32'h0));
        add_row(step_word(32'hFFFF_FFFF, 1'b1), 1'b1,
                fix_res(lmc_pkg::ST_HALT, 7'd0, 32'h0));
        add_row(ld_word(7'd0, 32'd901), 1'b1, fix_res(lmc_pkg::ST_OK, 7'd0, 32'h0));
        add_row(step_word(32'h1234, 1'b0), 1'b1,
                fix_res(lmc_pkg::ST_BAD_INPUT, 7'd0, 32'h0));
        add_row(step_word(32'h8000_0000, 1'b1), 1'b1,
                fix_res(lmc_pkg::ST_OK, 7'd1, 32'h8000_0000));
        add_row(ld_word(7'd1, 32'd922), 1'b0, '0);
        add_row(step_word(32'h0, 1'b1), 1'b0, '0);              // OTC, low byte 0
        add_row(ld_word(7'd2, 32'd199), 1'b0, '0);
        add_row(ld_word(7'd99, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(step_word(32'h0, 1'b1), 1'b0, '0);              // ADD wraps to max
        add_row(ld_word(7'd3, 32'd902), 1'b0, '0);
        add_row(step_word(32'h0, 1'b1), 1'b0, '0);              // OUT
        add_row(ld_word(7'd4, 32'hFFFF_FF9C), 1'b0, '0);        // negative word
        add_row(step_word(32'h0, 1'b1), 1'b1,
                fix_res(lmc_pkg::ST_BAD_INSTR, 7'd4, 32'h7FFF_FFFF));
        add_row(ld_word(7'd4, 32'd450), 1'b0, '0);              // opcode 4
        add_row(step_word(32'h0, 1'b1), 1'b1,
                fix_res(lmc_pkg::ST_BAD_INSTR, 7'd4, 32'h7FFF_FFFF));
        add_row(ld_word(7'd4, 32'd903), 1'b0, '0);              // unknown I/O code
        add_row(step_word(32'h0, 1'b1), 1'b1,
                fix_res(lmc_pkg::ST_BAD_INSTR, 7'd4, 32'h7FFF_FFFF));
        add_row(ld_word(7'd4, 32'd299), 1'b0, '0);
        add_row(step_word(32'h0, 1'b1), 1'b0, '0);              // SUB wraps to min
        add_row(ld_word(7'd5, 32'd396), 1'b0, '0);
        add_row(step_word(32'h0, 1'b1), 1'b0, '0);              // STA
        add_row(ld_word(7'd6, 32'd710), 1'b0, '0);
        add_row(step_word(32'h0, 1'b1), 1'b0, '0);              // BRZ not taken

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
            issue_word(dir_tab[k].word, next_gap(), dir_tab[k].fixed, dir_tab[k].res);

        // Random programs. A step from mailbox 99 that falls through would park
        // the PC at 100 for good, so mailbox 99 gets a BRA first.
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 2)
                drain_results();
            if (pc_img == 7'd99)
            begin
                issue_word(ld_word(7'd99, 32'(int'(lmc_pkg::OPC_BRA) * 100
                                              + $urandom_range(0, 98))),
                           next_gap(), 1'b0, '0);
                issue_word(step_word($urandom, 1'b1), next_gap(), 1'b0, '0);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        w = ld_word(pc_img, gen_instr());
                    else if (pick < 90)
                        w = ld_word(7'($urandom_range(0, 99)), gen_instr());
                    else
                        w = ld_word(7'($urandom_range(100, 127)), gen_instr());
                    w.input_value = $urandom;
                    w.input_ok    = 1'($urandom_range(0, 1));
                end
                else
                begin
                    w = step_word($urandom, $urandom_range(0, 99) < 85);
                    w.load_address = 7'($urandom_range(0, 127));
                    w.load_word    = $urandom;
                end
                issue_word(w, next_gap(), 1'b0, '0);
            end
        end

        // Run off the end of memory: BRA 99, then an LDA at 99 of the zero word at 98
        // leaves PC at 100, where every step is refused.
        issue_word(ld_word(pc_img, 32'(int'(lmc_pkg::OPC_BRA) * 100 + 99)),
                   next_gap(), 1'b0, '0);
        issue_word(step_word(32'h0, 1'b1), next_gap(), 1'b0, '0);
        issue_word(ld_word(7'd98, 32'h0), next_gap(), 1'b0, '0);
        issue_word(ld_word(7'd99, 32'(int'(lmc_pkg::OPC_LDA) * 100 + 98)),
                   next_gap(), 1'b0, '0);
        issue_word(step_word(32'h0, 1'b1), next_gap(), 1'b0, '0);
        issue_word(step_word(32'h55, 1'b1), next_gap(), 1'b1,
                   fix_res(lmc_pkg::ST_BAD_PC, 7'd100, 32'h0));
        issue_word(ld_word(7'd5, 32'd901), next_gap(), 1'b1,
                   fix_res(lmc_pkg::ST_OK, 7'd100, 32'h0));
        issue_word(step_word(32'h55, 1'b1), next_gap(), 1'b1,
                   fix_res(lmc_pkg::ST_BAD_PC, 7'd100, 32'h0));

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
